/* design/vt52_escape_decoder_core_assert.svh */
// ----------------------------------------------------------------------------
// VT52 escape decoder assertion macros
// Concurrent check macros shared by the decoder RTL. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef VT52_ESCAPE_DECODER_CORE_ASSERT_SVH
`define VT52_ESCAPE_DECODER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define VT52_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("vt52 check failed");

// Next-cycle implication
`define VT52_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("vt52 check failed");

`else

`define VT52_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define VT52_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* design/vt52_pkg.sv */
// ----------------------------------------------------------------------------
// VT52 escape decoder package
// Shared types, command codes, character codes and helpers.
// ----------------------------------------------------------------------------
package vt52_pkg;

  // Display command codes
  typedef enum logic [3:0] {
    OP_NONE        = 4'd0,
    OP_PAINT       = 4'd1,
    OP_PAINT_SCROLL= 4'd2,
    OP_CLEAR_SCR   = 4'd3,
    OP_CLEAR_SPAN  = 4'd4,
    OP_INS_LINE    = 4'd5,
    OP_DEL_LINE    = 4'd6,
    OP_CLEAR_LINE  = 4'd7,
    OP_BELL        = 4'd8
  } op_t;

  // Parser state, one-hot
  typedef enum logic [7:0] {
    PM_NORMAL = 8'b0000_0001,
    PM_ESC    = 8'b0000_0010,
    PM_ROW    = 8'b0000_0100,
    PM_COL    = 8'b0000_1000,
    PM_FG     = 8'b0001_0000,
    PM_BG     = 8'b0010_0000,
    PM_RATE   = 8'b0100_0000,
    PM_QUOTE  = 8'b1000_0000
  } pmode_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_LAST_COLUMN = 2'd0;
  localparam logic [1:0] CFG_LAST_ROW    = 2'd1;
  localparam logic [1:0] CFG_PLANE_COUNT = 2'd2;

  // Configuration reset values
  localparam logic [7:0] RST_LAST_COLUMN = 8'd79;
  localparam logic [7:0] RST_LAST_ROW    = 8'd24;
  localparam logic [3:0] RST_PLANE_COUNT = 4'd1;
  localparam logic [7:0] RST_PERIOD      = 8'd20;
  localparam logic [7:0] RST_FG          = 8'd1;

  // Control characters
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] POS_MASK = 8'h7f;

  // Escape sequence final characters
  localparam logic [7:0] ES_UP        = 8'h41; // A
  localparam logic [7:0] ES_DOWN      = 8'h42; // B
  localparam logic [7:0] ES_RIGHT     = 8'h43; // C
  localparam logic [7:0] ES_LEFT      = 8'h44; // D
  localparam logic [7:0] ES_CLEAR     = 8'h45; // E
  localparam logic [7:0] ES_HOME      = 8'h48; // H
  localparam logic [7:0] ES_REV_LF    = 8'h49; // I
  localparam logic [7:0] ES_CLR_EOS   = 8'h4a; // J
  localparam logic [7:0] ES_CLR_EOL   = 8'h4b; // K
  localparam logic [7:0] ES_INS_LINE  = 8'h4c; // L
  localparam logic [7:0] ES_DEL_LINE  = 8'h4d; // M
  localparam logic [7:0] ES_QUOTE     = 8'h51; // Q
  localparam logic [7:0] ES_ADDR      = 8'h59; // Y
  localparam logic [7:0] ES_SET_FG    = 8'h62; // b
  localparam logic [7:0] ES_SET_BG    = 8'h63; // c
  localparam logic [7:0] ES_CLR_BOS   = 8'h64; // d
  localparam logic [7:0] ES_CURS_ON   = 8'h65; // e
  localparam logic [7:0] ES_CURS_OFF  = 8'h66; // f
  localparam logic [7:0] ES_SAVE      = 8'h6a; // j
  localparam logic [7:0] ES_RESTORE   = 8'h6b; // k
  localparam logic [7:0] ES_CLR_LINE  = 8'h6c; // l
  localparam logic [7:0] ES_CLR_BOL   = 8'h6f; // o
  localparam logic [7:0] ES_INV_ON    = 8'h70; // p
  localparam logic [7:0] ES_INV_OFF   = 8'h71; // q
  localparam logic [7:0] ES_RATE      = 8'h74; // t
  localparam logic [7:0] ES_WRAP_ON   = 8'h76; // v
  localparam logic [7:0] ES_WRAP_OFF  = 8'h77; // w

  // Configuration as seen by the decoder
  typedef struct packed {
    logic [7:0] last_column;
    logic [7:0] last_row;
    logic [3:0] plane_count;
  } cfg_t;

  // One result item
  typedef struct packed {
    op_t        op;
    logic [7:0] col_a;
    logic [7:0] row_a;
    logic [7:0] col_b;
    logic [7:0] row_b;
    logic [7:0] glyph;
    logic [7:0] fore_colour;
    logic [7:0] back_colour;
    logic [7:0] cursor_col;
    logic [7:0] cursor_row;
    logic       cursor_visible;
    logic [7:0] blink_rate;
  } res_t;

  // Colour numbers keep plane_count low bits, all eight from eight planes up
  function automatic logic [7:0] colour_mask(input logic [3:0] planes);
    logic [7:0] m;
    m = 8'hff;
    if (planes < 4'd8) begin
      m = 8'((9'd1 << planes[2:0]) - 9'd1);
    end
    return m;
  endfunction

  // Limit a position to its highest allowed index
  function automatic logic [7:0] clamp(input logic [7:0] v, input logic [7:0] lim);
    return (v > lim) ? lim : v;
  endfunction

endpackage

/* design/vt52_dec.sv */
// ----------------------------------------------------------------------------
// VT52 decode stage
// Holds the parser and terminal state and turns one byte into one command.
// ----------------------------------------------------------------------------
module vt52_dec (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,       // decode the held byte this cycle
  input  logic [7:0]          char_byte,
  input  vt52_pkg::cfg_t      cfg,
  output vt52_pkg::res_t      res
);

  // Terminal state
  vt52_pkg::pmode_t mode_r, mode_nxt;
  logic [7:0] col_r, col_nxt;
  logic [7:0] row_r, row_nxt;
  logic [7:0] scol_r, scol_nxt;
  logic [7:0] srow_r, srow_nxt;
  logic [7:0] prow_r, prow_nxt;
  logic [7:0] fg_r, fg_nxt;
  logic [7:0] bg_r, bg_nxt;
  logic [7:0] period_r, period_nxt;
  logic       curs_r, curs_nxt;
  logic       blink_r, blink_nxt;
  logic       inv_r, inv_nxt;
  logic       wrap_r, wrap_nxt;

  // Scratch values
  vt52_pkg::op_t op;
  logic [7:0] ca, ra, cb, rb, glyph;
  logic       paint;
  logic [7:0] rel_c, rel_row, addr_x, addr_y;
  logic [8:0] tab_x;
  logic       at_bottom, at_right;

  always_comb begin
    rel_c     = char_byte - vt52_pkg::CH_SPACE;
    rel_row   = prow_r - vt52_pkg::CH_SPACE;
    addr_x    = rel_c & (cfg.last_column | vt52_pkg::POS_MASK);
    addr_y    = rel_row & (cfg.last_row | vt52_pkg::POS_MASK);
    tab_x     = {1'b0, col_r | 8'h07} + 9'd1;
    at_bottom = (row_r >= cfg.last_row);
    at_right  = (col_r >= cfg.last_column);
  end

  // Next state and command
  always_comb begin
    mode_nxt   = vt52_pkg::PM_NORMAL;
    col_nxt    = col_r;
    row_nxt    = row_r;
    scol_nxt   = scol_r;
    srow_nxt   = srow_r;
    prow_nxt   = prow_r;
    fg_nxt     = fg_r;
    bg_nxt     = bg_r;
    period_nxt = period_r;
    curs_nxt   = curs_r;
    blink_nxt  = blink_r;
    inv_nxt    = inv_r;
    wrap_nxt   = wrap_r;
    op         = vt52_pkg::OP_NONE;
    ca         = '0;
    ra         = '0;
    cb         = '0;
    rb         = '0;
    glyph      = '0;
    paint      = 1'b0;

    case (mode_r)
      vt52_pkg::PM_QUOTE: begin
        op    = vt52_pkg::OP_PAINT;
        paint = 1'b1;
        glyph = char_byte;
        ca    = col_r;
        ra    = row_r;
      end
      vt52_pkg::PM_ROW: begin
        prow_nxt = char_byte;
        mode_nxt = vt52_pkg::PM_COL;
      end
      vt52_pkg::PM_COL: begin
        col_nxt = vt52_pkg::clamp(addr_x, cfg.last_column);
        row_nxt = vt52_pkg::clamp(addr_y, cfg.last_row);
      end
      vt52_pkg::PM_FG: fg_nxt = char_byte & vt52_pkg::colour_mask(cfg.plane_count);
      vt52_pkg::PM_BG: bg_nxt = char_byte & vt52_pkg::colour_mask(cfg.plane_count);
      vt52_pkg::PM_RATE: begin
        if (rel_c == 8'd0) begin
          blink_nxt = 1'b0;
        end else begin
          blink_nxt  = 1'b1;
          period_nxt = rel_c;
        end
      end
      vt52_pkg::PM_ESC: begin
        case (char_byte)
          vt52_pkg::ES_UP:    if (row_r != 8'd0) row_nxt = row_r - 8'd1;
          vt52_pkg::ES_DOWN:  if (row_r < cfg.last_row) row_nxt = row_r + 8'd1;
          vt52_pkg::ES_RIGHT: if (col_r < cfg.last_column) col_nxt = col_r + 8'd1;
          vt52_pkg::ES_LEFT:  if (col_r != 8'd0) col_nxt = col_r - 8'd1;
          vt52_pkg::ES_CLEAR: begin
            op      = vt52_pkg::OP_CLEAR_SCR;
            col_nxt = '0;
            row_nxt = '0;
          end
          vt52_pkg::ES_HOME: begin
            col_nxt = '0;
            row_nxt = '0;
          end
          vt52_pkg::ES_REV_LF: begin
            if (row_r == 8'd0) op = vt52_pkg::OP_INS_LINE;
            else row_nxt = row_r - 8'd1;
          end
          vt52_pkg::ES_CLR_EOS: begin
            op = vt52_pkg::OP_CLEAR_SPAN;
            ca = col_r;
            ra = row_r;
            cb = cfg.last_column;
            rb = cfg.last_row;
          end
          vt52_pkg::ES_CLR_EOL: begin
            op = vt52_pkg::OP_CLEAR_SPAN;
            ca = col_r;
            ra = row_r;
            cb = cfg.last_column;
            rb = row_r;
          end
          vt52_pkg::ES_INS_LINE: begin
            col_nxt = '0;
            op      = vt52_pkg::OP_INS_LINE;
            ra      = row_r;
          end
          vt52_pkg::ES_DEL_LINE: begin
            col_nxt = '0;
            op      = vt52_pkg::OP_DEL_LINE;
            ra      = row_r;
          end
          vt52_pkg::ES_QUOTE:   mode_nxt = vt52_pkg::PM_QUOTE;
          vt52_pkg::ES_ADDR:    mode_nxt = vt52_pkg::PM_ROW;
          vt52_pkg::ES_SET_FG:  mode_nxt = vt52_pkg::PM_FG;
          vt52_pkg::ES_SET_BG:  mode_nxt = vt52_pkg::PM_BG;
          vt52_pkg::ES_CLR_BOS: begin
            op = vt52_pkg::OP_CLEAR_SPAN;
            cb = col_r;
            rb = row_r;
          end
          vt52_pkg::ES_CURS_ON:  curs_nxt = 1'b1;
          vt52_pkg::ES_CURS_OFF: curs_nxt = 1'b0;
          vt52_pkg::ES_SAVE: begin
            scol_nxt = col_r;
            srow_nxt = row_r;
          end
          vt52_pkg::ES_RESTORE: begin
            col_nxt = vt52_pkg::clamp(scol_r, cfg.last_column);
            row_nxt = vt52_pkg::clamp(srow_r, cfg.last_row);
          end
          vt52_pkg::ES_CLR_LINE: begin
            col_nxt = '0;
            op      = vt52_pkg::OP_CLEAR_LINE;
            ra      = row_r;
          end
          vt52_pkg::ES_CLR_BOL: begin
            op = vt52_pkg::OP_CLEAR_SPAN;
            ra = row_r;
            cb = col_r;
            rb = row_r;
          end
          vt52_pkg::ES_INV_ON:   inv_nxt  = 1'b1;
          vt52_pkg::ES_INV_OFF:  inv_nxt  = 1'b0;
          vt52_pkg::ES_RATE:     mode_nxt = vt52_pkg::PM_RATE;
          vt52_pkg::ES_WRAP_ON:  wrap_nxt = 1'b1;
          vt52_pkg::ES_WRAP_OFF: wrap_nxt = 1'b0;
          default: ;
        endcase
      end
      default: begin
        // Normal mode: control bytes or printable glyphs
        if (char_byte < vt52_pkg::CH_SPACE) begin
          case (char_byte)
            vt52_pkg::CH_CR: col_nxt = '0;
            vt52_pkg::CH_LF: begin
              if (at_bottom) op = vt52_pkg::OP_DEL_LINE;
              else row_nxt = row_r + 8'd1;
            end
            vt52_pkg::CH_BS:  if (col_r != 8'd0) col_nxt = col_r - 8'd1;
            vt52_pkg::CH_BEL: op = vt52_pkg::OP_BELL;
            vt52_pkg::CH_ESC: mode_nxt = vt52_pkg::PM_ESC;
            vt52_pkg::CH_TAB: begin
              if (col_r < cfg.last_column) begin
                col_nxt = (tab_x > {1'b0, cfg.last_column}) ? cfg.last_column : tab_x[7:0];
              end
            end
            default: ;
          endcase
        end else begin
          op    = vt52_pkg::OP_PAINT;
          paint = 1'b1;
          glyph = char_byte;
          ca    = col_r;
          ra    = row_r;
          if (at_right) begin
            if (wrap_r) begin
              if (at_bottom) op = vt52_pkg::OP_PAINT_SCROLL;
              else row_nxt = row_r + 8'd1;
              col_nxt = '0;
            end else begin
              col_nxt = cfg.last_column;
            end
          end else begin
            col_nxt = col_r + 8'd1;
          end
        end
      end
    endcase
  end

  // Result assembly from the updated state
  always_comb begin
    res.op             = op;
    res.col_a          = ca;
    res.row_a          = ra;
    res.col_b          = cb;
    res.row_b          = rb;
    res.glyph          = glyph;
    res.fore_colour    = (paint && inv_nxt) ? bg_nxt : fg_nxt;
    res.back_colour    = (paint && inv_nxt) ? fg_nxt : bg_nxt;
    res.cursor_col     = col_nxt;
    res.cursor_row     = row_nxt;
    res.cursor_visible = curs_nxt;
    res.blink_rate     = blink_nxt ? period_nxt : 8'd0;
  end

  // State registers, updated once per decoded byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= vt52_pkg::PM_NORMAL;
      col_r    <= '0;
      row_r    <= '0;
      scol_r   <= '0;
      srow_r   <= '0;
      prow_r   <= '0;
      fg_r     <= vt52_pkg::RST_FG;
      bg_r     <= '0;
      period_r <= vt52_pkg::RST_PERIOD;
      curs_r   <= 1'b1;
      blink_r  <= 1'b0;
      inv_r    <= 1'b0;
      wrap_r   <= 1'b0;
    end else if (take) begin
      mode_r   <= mode_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      scol_r   <= scol_nxt;
      srow_r   <= srow_nxt;
      prow_r   <= prow_nxt;
      fg_r     <= fg_nxt;
      bg_r     <= bg_nxt;
      period_r <= period_nxt;
      curs_r   <= curs_nxt;
      blink_r  <= blink_nxt;
      inv_r    <= inv_nxt;
      wrap_r   <= wrap_nxt;
    end
  end

endmodule

/* design/vt52_out.sv */
// ----------------------------------------------------------------------------
// VT52 result register
// Holds one command until the downstream side takes it.
// ----------------------------------------------------------------------------
module vt52_out (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  vt52_pkg::res_t res_in,
  input  logic           stall,
  output logic           ready,
  output logic           valid,
  output vt52_pkg::res_t res_out
);

  logic           valid_r, valid_nxt;
  vt52_pkg::res_t res_r;

  // Free when empty or when the held result transfers this cycle
  assign ready = !valid_r || !stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) valid_nxt = 1'b1;
    else if (!stall) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign valid   = valid_r;
  assign res_out = res_r;

endmodule

/* design/vt52_escape_decoder_core.sv */
// VT52 escape decoder: one console byte in, one display command out. A byte
// is taken into an input register and decoded against the terminal state
// once the result register is free; the command then lands in the result
// register. One byte per cycle is sustained while the output is not stalled;
// the cursor and parser state loop inside the decode stage sets that figure.
// Either side may stall at any time without loss. Configuration registers
// (last column, last row, plane count) must be written by the user only while
// the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
// VT52 escape decoder core
// Top level: input register, configuration registers, decode and result stage.
// ----------------------------------------------------------------------------
`include "vt52_escape_decoder_core_assert.svh"

module vt52_escape_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  // Configuration port
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  // Input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_byte,
  // Result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_op,
  output logic [7:0] out_col_a,
  output logic [7:0] out_row_a,
  output logic [7:0] out_col_b,
  output logic [7:0] out_row_b,
  output logic [7:0] out_glyph,
  output logic [7:0] out_fore_colour,
  output logic [7:0] out_back_colour,
  output logic [7:0] out_cursor_col,
  output logic [7:0] out_cursor_row,
  output logic       out_cursor_visible,
  output logic [7:0] out_blink_rate
);

  vt52_pkg::cfg_t cfg_r;
  logic           in_valid_r, in_valid_nxt;
  logic [7:0]     byte_r;
  logic           in_xfer, take, out_ready;
  vt52_pkg::res_t dec_res, held_res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.last_column <= vt52_pkg::RST_LAST_COLUMN;
      cfg_r.last_row    <= vt52_pkg::RST_LAST_ROW;
      cfg_r.plane_count <= vt52_pkg::RST_PLANE_COUNT;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        vt52_pkg::CFG_LAST_COLUMN: cfg_r.last_column <= cfg_data;
        vt52_pkg::CFG_LAST_ROW:    cfg_r.last_row    <= cfg_data;
        vt52_pkg::CFG_PLANE_COUNT: cfg_r.plane_count <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Input register: refills in the same cycle its byte is decoded
  assign take     = in_valid_r && out_ready;
  assign in_stall = in_valid_r && !out_ready;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_xfer) in_valid_nxt = 1'b1;
    else if (take) in_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      byte_r <= in_char_byte;
    end
  end

  // Decode against terminal state
  vt52_dec u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .char_byte (byte_r),
    .cfg       (cfg_r),
    .res       (dec_res)
  );

  // Result register
  vt52_out u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (take),
    .res_in  (dec_res),
    .stall   (out_stall),
    .ready   (out_ready),
    .valid   (out_valid),
    .res_out (held_res)
  );

  assign out_op             = held_res.op;
  assign out_col_a          = held_res.col_a;
  assign out_row_a          = held_res.row_a;
  assign out_col_b          = held_res.col_b;
  assign out_row_b          = held_res.row_b;
  assign out_glyph          = held_res.glyph;
  assign out_fore_colour    = held_res.fore_colour;
  assign out_back_colour    = held_res.back_colour;
  assign out_cursor_col     = held_res.cursor_col;
  assign out_cursor_row     = held_res.cursor_row;
  assign out_cursor_visible = held_res.cursor_visible;
  assign out_blink_rate     = held_res.blink_rate;

  // Checks
  // An empty input register never pushes back
  `VT52_ASSERT_NOW(a_no_false_stall, clk, rst_n, !in_valid_r, !in_stall)
  // A decoded byte always lands in the result register
  `VT52_ASSERT_NEXT(a_take_lands, clk, rst_n, take, out_valid)
  // Paint then scroll always leaves the cursor at the left edge
  `VT52_ASSERT_NOW(a_scroll_col0, clk, rst_n,
    out_valid && (out_op == vt52_pkg::OP_PAINT_SCROLL), out_cursor_col == 8'd0)
  // Only paint commands carry a glyph
  `VT52_ASSERT_NOW(a_glyph_paint, clk, rst_n,
    out_valid && (out_glyph != 8'd0),
    (out_op == vt52_pkg::OP_PAINT) || (out_op == vt52_pkg::OP_PAINT_SCROLL))

endmodule
